### rtl/cle_pkg.sv
// Circular list engine: shared constants, opcode/status codes, FSM state,
// and the command/status structs between controller and datapath. No dependencies.
package cle_pkg;

	localparam int NODES  = 16;
	localparam int DATA_W = 32;
	localparam int PTR_W  = $clog2(NODES);
	localparam int CNT_W  = $clog2(NODES + 1);
	localparam int OP_W   = 3;
	localparam int ST_W   = 2;

	typedef enum logic [OP_W-1:0] {
		OP_INS_BACK  = 3'd0,
		OP_INS_FRONT = 3'd1,
		OP_FIRST     = 3'd2,
		OP_NEXT      = 3'd3,
		OP_REMOVE    = 3'd4,
		OP_COUNT     = 3'd5
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_NOCUR = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ_B,
		S_EXEC,
		S_WRITE_B
	} state_t;

	typedef struct packed {
		logic accept;
		logic read_b;
		logic exec;
		logic write_b;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} stat_t;

endpackage

### rtl/cle_req_if.sv
// Request channel of the circular list engine: valid/ready plus opcode and data.
// Depends on cle_pkg.
interface cle_req_if;
	logic                        valid;
	logic                        ready;
	logic [cle_pkg::OP_W-1:0]    opcode;
	logic [cle_pkg::DATA_W-1:0]  value_in;

	modport source (output valid, output opcode, output value_in, input ready);
	modport sink   (input valid, input opcode, input value_in, output ready);
endinterface

### rtl/cle_rsp_if.sv
// Response channel of the circular list engine: valid/ready plus status, data, length.
// Depends on cle_pkg.
interface cle_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [cle_pkg::ST_W-1:0]    status;
	logic [cle_pkg::DATA_W-1:0]  value_out;
	logic [cle_pkg::CNT_W-1:0]   length;

	modport source (output valid, output status, output value_out, output length, input ready);
	modport sink   (input valid, input status, input value_out, input length, output ready);
endinterface

### rtl/cle_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/cle_ctrl.sv
// Controller FSM: sequences read A, read B, execute, second write and result hand-off.
// Depends on cle_pkg.
module cle_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output cle_pkg::cmd_t  cmd,
	input  cle_pkg::stat_t stat
);

	cle_pkg::state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cle_pkg::S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			cle_pkg::S_IDLE: begin
				if (in_valid) state_n = cle_pkg::S_READ_B;
			end
			cle_pkg::S_READ_B:  state_n = cle_pkg::S_EXEC;
			cle_pkg::S_EXEC:    state_n = cle_pkg::S_WRITE_B;
			cle_pkg::S_WRITE_B: begin
				if (stat.out_free) state_n = cle_pkg::S_IDLE;
			end
			default: state_n = cle_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd         = '0;
		case (state_q)
			cle_pkg::S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			cle_pkg::S_READ_B: cmd.read_b = 1'b1;
			cle_pkg::S_EXEC:   cmd.exec   = 1'b1;
			cle_pkg::S_WRITE_B: begin
				// second link write repeats harmlessly while the result slot is busy
				cmd.write_b = 1'b1;
				cmd.finish  = stat.out_free;
			end
			default: ;
		endcase
	end

endmodule

### rtl/cle_dp.sv
// Datapath: list pointers, allocator, link and value RAMs, result register.
// Depends on cle_pkg and cle_ram.
module cle_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cle_pkg::cmd_t                cmd,
	output cle_pkg::stat_t               stat,
	input  logic [cle_pkg::OP_W-1:0]     in_opcode,
	input  logic [cle_pkg::DATA_W-1:0]   in_value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [cle_pkg::ST_W-1:0]     out_status,
	output logic [cle_pkg::DATA_W-1:0]   out_value,
	output logic [cle_pkg::CNT_W-1:0]    out_length
);

	localparam int PW = cle_pkg::PTR_W;
	localparam int CW = cle_pkg::CNT_W;
	localparam int DW = cle_pkg::DATA_W;

	// list state
	logic [PW-1:0] tail_q, cursor_q, trail_q, free_head_q;
	logic          empty_q, cur_valid_q, free_ne_q;
	logic [CW-1:0] count_q, fresh_q;
	logic [PW-1:0] tail_n, cursor_n, trail_n, free_head_n;
	logic          empty_n, cur_valid_n, free_ne_n;
	logic [CW-1:0] count_n, fresh_n;

	// per-transaction registers
	logic [cle_pkg::OP_W-1:0] op_q;
	logic [DW-1:0]            val_q;
	logic [PW-1:0]            a_q;
	logic                     wb_en_q;
	logic [PW-1:0]            wb_addr_q, wb_data_q;
	logic [cle_pkg::ST_W-1:0] st_q;
	logic [DW-1:0]            res_q;

	logic                     wb_en_n;
	logic [PW-1:0]            wb_addr_n, wb_data_n;
	logic [cle_pkg::ST_W-1:0] st_n;
	logic [DW-1:0]            res_n;

	// RAM ports
	logic          link_we, lw_en, vw_en;
	logic [PW-1:0] link_waddr, link_wdata, link_raddr, link_rdata;
	logic [PW-1:0] lw_addr, lw_data;
	logic [PW-1:0] val_raddr;
	logic [DW-1:0] val_rdata;

	logic          fresh_avail;
	logic [PW-1:0] alloc;
	logic          out_valid_q;

	cle_ram #(.WIDTH(PW), .DEPTH(cle_pkg::NODES)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	cle_ram #(.WIDTH(DW), .DEPTH(cle_pkg::NODES)) u_value_ram (
		.clk   (clk),
		.we    (vw_en & cmd.exec),
		.waddr (alloc),
		.wdata (val_q),
		.raddr (val_raddr),
		.rdata (val_rdata)
	);

	// first link read is issued from the incoming opcode, second from the latched one
	always_comb begin
		if (cmd.read_b) begin
			link_raddr = (op_q == cle_pkg::OP_REMOVE) ? cursor_q : tail_q;
		end else begin
			case (in_opcode)
				cle_pkg::OP_INS_BACK,
				cle_pkg::OP_INS_FRONT: link_raddr = free_head_q;
				cle_pkg::OP_NEXT:      link_raddr = cursor_q;
				cle_pkg::OP_REMOVE:    link_raddr = trail_q;
				default:               link_raddr = tail_q;
			endcase
		end
		val_raddr = (op_q == cle_pkg::OP_REMOVE) ? cursor_q : link_rdata;
	end

	assign fresh_avail = fresh_q < CW'(cle_pkg::NODES);
	assign alloc       = fresh_avail ? fresh_q[PW-1:0] : free_head_q;

	always_comb begin
		tail_n      = tail_q;
		cursor_n    = cursor_q;
		trail_n     = trail_q;
		free_head_n = free_head_q;
		empty_n     = empty_q;
		cur_valid_n = cur_valid_q;
		free_ne_n   = free_ne_q;
		count_n     = count_q;
		fresh_n     = fresh_q;
		st_n        = cle_pkg::ST_OK;
		res_n       = '0;
		lw_en       = 1'b0;
		lw_addr     = alloc;
		lw_data     = link_rdata;
		vw_en       = 1'b0;
		wb_en_n     = 1'b0;
		wb_addr_n   = tail_q;
		wb_data_n   = alloc;
		case (op_q)
			cle_pkg::OP_INS_BACK,
			cle_pkg::OP_INS_FRONT: begin
				if (!fresh_avail && !free_ne_q) begin
					st_n = cle_pkg::ST_FULL;
				end else begin
					if (fresh_avail) begin
						fresh_n = fresh_q + CW'(1);
					end else begin
						free_head_n = a_q;
						free_ne_n   = (count_q + CW'(1)) < CW'(cle_pkg::NODES);
					end
					vw_en = 1'b1;
					lw_en = 1'b1;
					if (empty_q) begin
						lw_data = alloc;
						tail_n  = alloc;
						empty_n = 1'b0;
					end else begin
						// link_rdata holds the current head (tail's successor)
						lw_data = link_rdata;
						if (cur_valid_q && trail_q == tail_q && link_rdata == cursor_q) begin
							trail_n = alloc;
						end
						wb_en_n   = 1'b1;
						wb_addr_n = tail_q;
						wb_data_n = alloc;
						if (op_q == cle_pkg::OP_INS_BACK) tail_n = alloc;
					end
					count_n = count_q + CW'(1);
				end
			end
			cle_pkg::OP_FIRST: begin
				if (empty_q) begin
					st_n = cle_pkg::ST_EMPTY;
				end else begin
					trail_n     = tail_q;
					cursor_n    = a_q;
					cur_valid_n = 1'b1;
					res_n       = val_rdata;
				end
			end
			cle_pkg::OP_NEXT: begin
				if (empty_q) begin
					st_n = cle_pkg::ST_EMPTY;
				end else if (!cur_valid_q) begin
					st_n = cle_pkg::ST_NOCUR;
				end else begin
					trail_n  = cursor_q;
					cursor_n = a_q;
					res_n    = val_rdata;
				end
			end
			cle_pkg::OP_REMOVE: begin
				// a_q = link[trail], link_rdata = link[cursor]
				if (empty_q) begin
					st_n = cle_pkg::ST_EMPTY;
				end else if (!cur_valid_q || a_q != cursor_q) begin
					st_n = cle_pkg::ST_NOCUR;
				end else begin
					res_n = val_rdata;
					if (cursor_q == tail_q) begin
						if (link_rdata == cursor_q) begin
							empty_n     = 1'b1;
							cur_valid_n = 1'b0;
							tail_n      = '0;
						end else begin
							tail_n = trail_q;
						end
					end
					lw_en       = 1'b1;
					lw_addr     = trail_q;
					lw_data     = link_rdata;
					wb_en_n     = 1'b1;
					wb_addr_n   = cursor_q;
					wb_data_n   = free_head_q;
					cursor_n    = trail_q;
					free_head_n = cursor_q;
					free_ne_n   = 1'b1;
					if (count_q != '0) count_n = count_q - CW'(1);
				end
			end
			default: ;
		endcase
	end

	assign link_we    = (cmd.exec & lw_en) | (cmd.write_b & wb_en_q);
	assign link_waddr = cmd.write_b ? wb_addr_q : lw_addr;
	assign link_wdata = cmd.write_b ? wb_data_q : lw_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_q      <= '0;
			cursor_q    <= '0;
			trail_q     <= '0;
			free_head_q <= '0;
			empty_q     <= 1'b1;
			cur_valid_q <= 1'b0;
			free_ne_q   <= 1'b0;
			count_q     <= '0;
			fresh_q     <= '0;
			wb_en_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				tail_q      <= tail_n;
				cursor_q    <= cursor_n;
				trail_q     <= trail_n;
				free_head_q <= free_head_n;
				empty_q     <= empty_n;
				cur_valid_q <= cur_valid_n;
				free_ne_q   <= free_ne_n;
				count_q     <= count_n;
				fresh_q     <= fresh_n;
				wb_en_q     <= wb_en_n;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q  <= in_opcode;
			val_q <= in_value;
		end
		if (cmd.read_b) begin
			a_q <= link_rdata;
		end
		if (cmd.exec) begin
			wb_addr_q <= wb_addr_n;
			wb_data_q <= wb_data_n;
			st_q      <= st_n;
			res_q     <= res_n;
		end
		if (cmd.finish) begin
			out_status <= st_q;
			out_value  <= res_q;
			out_length <= count_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign stat.out_free = !out_valid_q || out_ready;

endmodule

### rtl/circular_list_engine.sv
// Circular singly linked list engine over a 16-node store with a free list.
// The result is registered at the end of the final write step; a result still held
// at the output stalls the final write step until the receiver takes it.
// A new request is taken only after the previous one finishes: two dependent link reads,
// then two link writes through the one write port, the second overlapping the result hand-off.
// Reset (arst_n, async): list empty, no cursor, no allocations; RAM contents undefined.
module circular_list_engine (
	input  logic     clk,
	input  logic     arst_n,
	cle_req_if.sink  req,
	cle_rsp_if.source rsp
);

	cle_pkg::cmd_t  cmd;
	cle_pkg::stat_t stat;

	cle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	cle_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_opcode  (req.opcode),
		.in_value   (req.value_in),
		.out_valid  (rsp.valid),
		.out_ready  (rsp.ready),
		.out_status (rsp.status),
		.out_value  (rsp.value_out),
		.out_length (rsp.length)
	);

endmodule

### sim/cle_list_checker.sv
// Scoreboard for the circular list engine: watches both channels, predicts each
// response from its own copy of the ring, free list and cursor, and counts mismatches.
// Depends on cle_pkg, cle_req_if, cle_rsp_if.
module cle_list_checker
	import cle_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	cle_req_if   req,
	cle_rsp_if   rsp,
	output int   errors,
	output int   pending
);

	typedef struct packed {
		status_t            status;
		logic [DATA_W-1:0]  value;
		logic [CNT_W-1:0]   length;
	} list_result_t;

	logic [PTR_W-1:0]  next_of [NODES];
	logic [DATA_W-1:0] data_of [NODES];
	logic [PTR_W-1:0]  tail, cursor, trail, free_top;
	logic              ring_empty, cursor_live, free_live;
	logic [CNT_W-1:0]  occupancy, fresh_used;

	list_result_t awaited_results [$];
	int fail_count = 0;

	assign errors = fail_count;

	task automatic report(input string what, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		$display("mismatch: %s expected %0h got %0h", what, want, got);
		fail_count++;
	endtask

	// Allocate a node (never-used slots first, then the free list) and link it after the tail.
	function automatic status_t link_in(input logic [DATA_W-1:0] v, input bit at_back);
		logic [PTR_W-1:0] n, head;
		if (fresh_used < NODES) begin
			n = fresh_used[PTR_W-1:0];
			fresh_used++;
		end else if (free_live) begin
			n = free_top;
			free_top = next_of[n];
			free_live = (occupancy + 1) < NODES;
		end else begin
			return ST_FULL;
		end
		data_of[n] = v;
		if (ring_empty) begin
			next_of[n] = n;
			tail = n;
			ring_empty = 1'b0;
		end else begin
			head = next_of[tail];
			// new node lands between trail and cursor: keep trail linking to cursor
			if (cursor_live && trail == tail && head == cursor)
				trail = n;
			next_of[n] = head;
			next_of[tail] = n;
			if (at_back)
				tail = n;
		end
		occupancy++;
		return ST_OK;
	endfunction

	function automatic list_result_t apply_list_op(input logic [OP_W-1:0] op,
			input logic [DATA_W-1:0] v);
		list_result_t r;
		logic [PTR_W-1:0] rm, bk;
		r.status = ST_OK;
		r.value = '0;
		case (op)
			OP_INS_BACK, OP_INS_FRONT: r.status = link_in(v, op == OP_INS_BACK);
			OP_FIRST: begin
				if (ring_empty) begin
					r.status = ST_EMPTY;
				end else begin
					trail = tail;
					cursor = next_of[trail];
					cursor_live = 1'b1;
					r.value = data_of[cursor];
				end
			end
			OP_NEXT: begin
				if (ring_empty) begin
					r.status = ST_EMPTY;
				end else if (!cursor_live) begin
					r.status = ST_NOCUR;
				end else begin
					trail = cursor;
					cursor = next_of[trail];
					r.value = data_of[cursor];
				end
			end
			OP_REMOVE: begin
				if (ring_empty) begin
					r.status = ST_EMPTY;
				end else if (!cursor_live || next_of[trail] != cursor) begin
					r.status = ST_NOCUR;
				end else begin
					rm = cursor;
					bk = trail;
					r.value = data_of[rm];
					if (rm == tail) begin
						if (next_of[rm] == rm) begin
							ring_empty = 1'b1;
							cursor_live = 1'b0;
							tail = '0;
						end else begin
							tail = bk;
						end
					end
					next_of[bk] = next_of[rm];
					cursor = bk;
					next_of[rm] = free_top;
					free_top = rm;
					free_live = 1'b1;
					if (occupancy > 0)
						occupancy--;
				end
			end
			default: ;
		endcase
		r.length = occupancy;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		list_result_t exp;
		if (!arst_n) begin
			tail = '0;
			cursor = '0;
			trail = '0;
			free_top = '0;
			ring_empty = 1'b1;
			cursor_live = 1'b0;
			free_live = 1'b0;
			occupancy = '0;
			fresh_used = '0;
			awaited_results.delete();
			pending <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (awaited_results.size() == 0) begin
					report("unexpected response, status", '0, rsp.status);
				end else begin
					exp = awaited_results.pop_front();
					if (rsp.status !== exp.status)
						report("status", exp.status, rsp.status);
					if (rsp.value_out !== exp.value)
						report("value_out", exp.value, rsp.value_out);
					if (rsp.length !== exp.length)
						report("length", exp.length, rsp.length);
				end
			end
			if (req.valid && req.ready)
				awaited_results.push_back(apply_list_op(req.opcode, req.value_in));
			pending <= awaited_results.size();
		end
	end

endmodule

### sim/circular_list_engine_tb.sv
// Testbench top for the circular list engine: clock, reset, request stimulus and
// response back-pressure; the verdict comes from cle_list_checker's error count.
// Depends on cle_pkg, cle_req_if, cle_rsp_if, circular_list_engine, cle_list_checker.
module circular_list_engine_tb;
	import cle_pkg::*;

	localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;
	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASES      = 17;
	localparam int PHASE_ITEMS = 50;
	localparam int LONG_HOLD   = 80;

	localparam int MODE_FILL = 0;
	localparam int MODE_WALK = 1;
	localparam int MODE_MIX  = 2;

	logic clk = 1'b0;
	logic arst_n;
	int   fail_count;
	int   outstanding;
	int   cycle_count = 0;
	bit   idle_on = 1'b1;
	bit   hold_rsp = 1'b0;

	cle_req_if req_ch ();
	cle_rsp_if rsp_ch ();

	circular_list_engine i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	cle_list_checker i_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.errors  (fail_count),
		.pending (outstanding)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL circular_list_engine");
			$finish;
		end
	end

	// Offer one transaction, with an optional idle burst first; returns at the accepting edge.
	task automatic send_op(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.opcode   <= op;
		req_ch.value_in <= val;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	// Stop offering until every outstanding response has come back.
	task automatic drain_list;
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	function automatic logic [DATA_W-1:0] pick_word;
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [OP_W-1:0] pick_op(input int mode);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 2)
			return roll[0] ? OP_SPARE7 : OP_SPARE6;
		case (mode)
			MODE_FILL: begin
				if (roll < 50) return OP_INS_BACK;
				if (roll < 85) return OP_INS_FRONT;
				if (roll < 90) return OP_FIRST;
				if (roll < 95) return OP_NEXT;
				return OP_REMOVE;
			end
			MODE_WALK: begin
				if (roll < 10) return OP_INS_BACK;
				if (roll < 17) return OP_INS_FRONT;
				if (roll < 30) return OP_FIRST;
				if (roll < 62) return OP_NEXT;
				if (roll < 97) return OP_REMOVE;
				return OP_COUNT;
			end
			default: return op_t'($urandom_range(0, 5));
		endcase
	endfunction

	// Response side: random ready bursts, plus one long hold-off on request.
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_rsp = 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		int mode;
		req_ch.valid    = 1'b0;
		req_ch.opcode   = OP_COUNT;
		req_ch.value_in = '0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty-list errors
		send_op(OP_COUNT, 32'h0);
		send_op(OP_FIRST, 32'h0);
		send_op(OP_NEXT, 32'h0);
		send_op(OP_REMOVE, 32'h0);
		send_op(OP_INS_BACK, 32'hFFFF_FFFF);
		// no cursor yet
		send_op(OP_NEXT, 32'h0);
		send_op(OP_REMOVE, 32'h0);
		send_op(OP_INS_FRONT, 32'h0000_0000);
		send_op(OP_FIRST, 32'h0);
		// insert between trail and cursor while iterating
		send_op(OP_INS_BACK, 32'h1234_5678);
		send_op(OP_REMOVE, 32'h0);
		// second remove without next is refused
		send_op(OP_REMOVE, 32'h0);
		send_op(OP_NEXT, 32'h0);
		send_op(OP_SPARE6, 32'hA5A5_A5A5);
		send_op(OP_SPARE7, 32'h5A5A_5A5A);
		send_op(OP_FIRST, 32'h0);
		send_op(OP_REMOVE, 32'h0);
		// single node left: remove empties the list
		send_op(OP_REMOVE, 32'h0);
		send_op(OP_NEXT, 32'h0);
		send_op(OP_COUNT, 32'h0);
		send_op(OP_INS_FRONT, 32'hFFFF_FFFF);
		send_op(OP_FIRST, 32'h0);
		send_op(OP_NEXT, 32'h0);

		for (int ph = 0; ph < PHASES; ph++) begin
			mode = (ph == 0) ? MODE_FILL : $urandom_range(MODE_MIX, MODE_FILL);
			idle_on = (ph >= PHASES - 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
			if (ph == 3)
				hold_rsp = 1'b1;
			if (ph == 6)
				drain_list();
			for (int k = 0; k < PHASE_ITEMS; k++)
				send_op(pick_op(mode), pick_word());
		end

		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("PASS circular_list_engine");
		else
			$display("FAIL circular_list_engine");
		$finish;
	end

endmodule
